// ===== rtl/cdr_pkg.sv =====
// Shared types and constants for the circular deque ring.
`timescale 1ns / 1ps
`default_nettype none

package cdr_pkg;

  localparam int unsigned CAP_DEFAULT = 16;
  localparam int unsigned CAP_MIN     = 2;
  localparam int unsigned CAP_MAX     = 64;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // request codes as seen on the input port
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DROP_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DROP_BACK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_LIST       = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_DROP_FRONT,
    OP_DROP_BACK,
    OP_LIST
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // command queue between the decode stage and the execute stage
  localparam int unsigned CMD_FIFO_DEPTH = 2;
  localparam int unsigned CMD_PTR_W      = $clog2(CMD_FIFO_DEPTH);

endpackage

`default_nettype wire

// ===== rtl/circular_deque_ring.sv =====
// Top level of the circular deque ring: decode stage, command queue, execute stage.
`timescale 1ns / 1ps
`default_nettype none

// Bounded double-ended queue of CAPACITY signed 32-bit words held in a ring store.
// Requests enter through a register stage that drops undefined codes, wait in a
// two-entry command queue, and are carried out one at a time by the execute stage,
// which owns the store, the front pointer, the count and the output register.
// A push or drop is carried out in the execute stage and yields one word, so such
// requests flow at one per cycle while the output is taken and no list is under way;
// a list first loads the registered read port of the store from the front pointer
// and then yields one word per stored element, or a single empty word when the deque
// is empty. Push on full reports full, drop on empty reports empty, and neither
// changes the state.
module circular_deque_ring #(
  parameter int unsigned CAPACITY = cdr_pkg::CAP_DEFAULT
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [cdr_pkg::REQ_W-1:0]           req_type_i,
  input  wire logic signed [cdr_pkg::VALUE_W-1:0]  value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [cdr_pkg::STATUS_W-1:0]             status_o,
  output logic signed [cdr_pkg::VALUE_W-1:0]       element_o,
  output logic                                     last_o
);
  import cdr_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic            f_valid, f_ready;
  cmd_t            f_cmd;
  logic            b_valid, b_ready;
  cmd_t            b_cmd;
  logic [CntW-1:0] count;

  cdr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  cdr_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  cdr_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .last_o      (last_o),
    .count_o     (count)
  );

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count == $past(count) || count == $past(count) + 1'b1 ||
    count == $past(count) - 1'b1)
    else $error("element count moved by more than one");

  a_error_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_o && element_o == '0)
    else $error("error word must be last and carry zero");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_EMPTY || status_o == ST_FULL)
    else $error("undefined status code");

endmodule

`default_nettype wire

// ===== rtl/cdr_front.sv =====
// Request decode stage: takes input words, drops undefined codes, registers commands.
`timescale 1ns / 1ps
`default_nettype none

module cdr_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [cdr_pkg::REQ_W-1:0]         req_type_i,
  input  wire logic signed [cdr_pkg::VALUE_W-1:0] value_i,
  output logic                                   cmd_valid_o,
  input  wire logic                              cmd_ready_i,
  output cdr_pkg::cmd_t                          cmd_o
);
  import cdr_pkg::*;

  logic  vld_q, vld_d;
  cmd_t  cmd_q, cmd_d;
  op_e   op;
  logic  op_ok;
  logic  accept, fire;

  always_comb begin
    op    = OP_LIST;
    op_ok = 1'b1;
    unique case (req_type_i)
      REQ_PUSH_FRONT: op = OP_PUSH_FRONT;
      REQ_PUSH_BACK:  op = OP_PUSH_BACK;
      REQ_DROP_FRONT: op = OP_DROP_FRONT;
      REQ_DROP_BACK:  op = OP_DROP_BACK;
      REQ_LIST:       op = OP_LIST;
      default:        op_ok = 1'b0;  // undefined code: accepted, no effect
    endcase
  end

  assign fire       = vld_q & cmd_ready_i;
  assign in_ready_o = ~vld_q | cmd_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    vld_d = (vld_q & ~fire) | (accept & op_ok);
    cmd_d = cmd_q;
    if (accept) begin
      cmd_d.op    = op;
      cmd_d.value = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

`default_nettype wire

// ===== rtl/cdr_cmd_fifo.sv =====
// Short command queue between decode and execute stages.
`timescale 1ns / 1ps
`default_nettype none

module cdr_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire cdr_pkg::cmd_t  wr_data_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output cdr_pkg::cmd_t       rd_data_o
);
  import cdr_pkg::*;

  localparam int unsigned CntW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t                 entries_q [CMD_FIFO_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMD_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 push, pop;

  assign wr_ready_o = cnt_q != CntW'(CMD_FIFO_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_data_o  = entries_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == CMD_PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cdr_back.sv =====
// Execute stage: ring store, front pointer and count, list sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none

module cdr_back #(
  parameter int unsigned CAPACITY = cdr_pkg::CAP_DEFAULT,
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cmd_valid_i,
  output logic                                    cmd_ready_o,
  input  wire cdr_pkg::cmd_t                      cmd_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [cdr_pkg::STATUS_W-1:0]            status_o,
  output logic signed [cdr_pkg::VALUE_W-1:0]      element_o,
  output logic                                    last_o,
  output logic [CntW-1:0]                         count_o
);
  import cdr_pkg::*;

  localparam int unsigned SumW = CntW + 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_e;

  state_e                     state_q, state_d;
  logic [IdxW-1:0]            front_q, front_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [IdxW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]            rem_q, rem_d;
  logic                       out_vld_q, out_vld_d;
  status_e                    status_q, status_d;
  logic signed [VALUE_W-1:0]  element_q, element_d;
  logic                       last_q, last_d;

  logic signed [VALUE_W-1:0]  mem_q [CAPACITY];
  logic signed [VALUE_W-1:0]  rd_q;
  logic                       mem_we;
  logic [IdxW-1:0]            mem_wa;

  logic                       out_free, is_full, is_empty;
  logic [SumW-1:0]            back_sum;
  logic [IdxW-1:0]            back_pos, front_dec, front_inc;

  function automatic logic [IdxW-1:0] ring_inc(input logic [IdxW-1:0] p);
    ring_inc = (p == IdxW'(CAPACITY - 1)) ? '0 : p + 1'b1;
  endfunction

  assign out_free  = ~out_vld_q | out_ready_i;
  assign is_full   = cnt_q == CntW'(CAPACITY);
  assign is_empty  = cnt_q == '0;
  assign back_sum  = SumW'(front_q) + SumW'(cnt_q);
  assign back_pos  = (back_sum >= SumW'(CAPACITY)) ? IdxW'(back_sum - SumW'(CAPACITY))
                                                   : IdxW'(back_sum);
  assign front_dec = (front_q == '0) ? IdxW'(CAPACITY - 1) : front_q - 1'b1;
  assign front_inc = ring_inc(front_q);

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    rem_d       = rem_q;
    out_vld_d   = out_vld_q & ~out_ready_i;
    status_d    = status_q;
    element_d   = element_q;
    last_d      = last_q;
    mem_we      = 1'b0;
    mem_wa      = back_pos;
    cmd_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = out_free;
        if (cmd_valid_i && out_free) begin
          out_vld_d = 1'b1;
          status_d  = ST_OK;
          element_d = '0;
          last_d    = 1'b1;
          unique case (cmd_i.op)
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                front_d = front_dec;
                mem_we  = 1'b1;
                mem_wa  = front_dec;
                cnt_d   = cnt_q + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we = 1'b1;
                mem_wa = back_pos;
                cnt_d  = cnt_q + 1'b1;
              end
            end
            OP_DROP_FRONT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                front_d = front_inc;
                cnt_d   = cnt_q - 1'b1;
              end
            end
            OP_DROP_BACK: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            OP_LIST: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                // the walk emits its words; nothing to show yet
                out_vld_d = 1'b0;
                rd_ptr_d  = front_q;
                rem_d     = cnt_q;
                state_d   = S_LIST;
              end
            end
            default: out_vld_d = 1'b0;
          endcase
        end
      end
      S_LIST: begin
        // rd_q already holds the entry at rd_ptr_q
        if (out_free) begin
          out_vld_d = 1'b1;
          status_d  = ST_OK;
          element_d = rd_q;
          last_d    = rem_q == CntW'(1);
          rem_d     = rem_q - 1'b1;
          rd_ptr_d  = ring_inc(rd_ptr_q);
          if (rem_q == CntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      front_q   <= '0;
      cnt_q     <= '0;
      rd_ptr_q  <= '0;
      rem_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      cnt_q     <= cnt_d;
      rd_ptr_q  <= rd_ptr_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  // ring store: one write port, one registered read port addressed ahead
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= cmd_i.value;
    end
    rd_q <= mem_q[rd_ptr_d];
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign last_o      = last_q;
  assign count_o     = cnt_q;

endmodule

`default_nettype wire

// ===== sim/circular_deque_ring_test.sv =====
// Self-checking testbench for circular_deque_ring: random and directed requests against a predictor.
`timescale 1ns / 1ps

module circular_deque_ring_test;
  import cdr_pkg::*;

  localparam int unsigned DEPTH = CAP_DEFAULT;
  localparam int unsigned HOLD_LEN = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  // codes the block must swallow without a reply
  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  typedef struct {
    logic [REQ_W-1:0]          req;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct {
    status_e                   status;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
  } reply_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [REQ_W-1:0]          req_type_i = '0;
  logic signed [VALUE_W-1:0] value_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [STATUS_W-1:0]       status_o;
  logic signed [VALUE_W-1:0] element_o;
  logic                      last_o;

  request_t pending_reqs[$];
  reply_t   expected_replies[$];

  // shadow deque
  logic signed [VALUE_W-1:0] shadow_words[DEPTH];
  int unsigned               shadow_front = 0;
  int unsigned               shadow_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatch_count = 0;
  logic        in_taken = 1'b0;

  circular_deque_ring #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_o   (status_o),
    .element_o  (element_o),
    .last_o     (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void add_reply(status_e st, logic signed [VALUE_W-1:0] elem, logic lst);
    reply_t r;
    r.status  = st;
    r.element = elem;
    r.last    = lst;
    expected_replies.push_back(r);
  endfunction

  // apply one accepted request to the shadow deque and queue its replies
  function automatic void predict_deque(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] val);
    int unsigned i;
    case (req)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          add_reply(ST_FULL, '0, 1'b1);
        end else begin
          if (req == REQ_PUSH_FRONT) begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_words[shadow_front] = val;
          end else begin
            shadow_words[(shadow_front + shadow_count) % DEPTH] = val;
          end
          shadow_count++;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      REQ_DROP_FRONT, REQ_DROP_BACK: begin
        if (shadow_count == 0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          if (req == REQ_DROP_FRONT) shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
          add_reply(ST_OK, '0, 1'b1);
        end
      end
      REQ_LIST: begin
        if (shadow_count == 0) begin
          add_reply(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            add_reply(ST_OK, shadow_words[(shadow_front + i) % DEPTH], i + 1 == shadow_count);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // sender: one word in flight at a time, held until taken
  always @(negedge clk_i) begin : drive_requests
    request_t item;
    if (!in_valid_i || in_taken) begin
      if (rst_ni && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        item = pending_reqs.pop_front();
        in_valid_i <= 1'b1;
        req_type_i <= item.req;
        value_i    <= item.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus a long hold-off when the stimulus asks for one
  always @(negedge clk_i) begin
    if (hold_seen != hold_requests) begin
      hold_seen   <= hold_requests;
      hold_left   <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin : watch_ports
    reply_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        predict_deque(req_type_i, value_i);
        accepted_count++;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected word", element_o, '0);
        end else begin
          want = expected_replies.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", VALUE_W'(status_o), VALUE_W'(want.status));
          if (element_o !== want.element) report_mismatch("element", element_o, want.element);
          if (last_o !== want.last)
            report_mismatch("last", VALUE_W'(last_o), VALUE_W'(want.last));
        end
      end
    end
  end

  function automatic void queue_request(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] val);
    request_t r;
    r.req   = req;
    r.value = val;
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  // weights in percent; the remainder goes to undefined codes
  function automatic logic [REQ_W-1:0] pick_request(int unsigned push_w, int unsigned drop_w,
                                                     int unsigned list_w);
    int unsigned r;
    r = $urandom_range(99);
    if (r < push_w) return $urandom_range(1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    if (r < push_w + drop_w) return $urandom_range(1) ? REQ_DROP_FRONT : REQ_DROP_BACK;
    if (r < push_w + drop_w + list_w) return REQ_LIST;
    case ($urandom_range(2))
      0: return REQ_RSVD_5;
      1: return REQ_RSVD_6;
      default: return REQ_RSVD_7;
    endcase
  endfunction

  // bursts that mostly fill, mostly drain, or mix, so both ends of the ring get hit
  task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned n);
    int unsigned done;
    int unsigned len;
    int unsigned mode;
    int unsigned k;
    logic [REQ_W-1:0] req;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < n) begin
      len  = $urandom_range(4, 14);
      mode = $urandom_range(2);
      for (k = 0; k < len; k++) begin
        case (mode)
          0: req = pick_request(72, 13, 10);
          1: req = pick_request(13, 72, 10);
          default: req = pick_request(38, 34, 20);
        endcase
        queue_request(req, pick_value());
        if (req <= REQ_LIST) done++;
      end
    end
    while (accepted_count != queued_count) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned k;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty corners, extremes, ring wrap at the front, ignored codes
    queue_request(REQ_LIST, 32'sd7);
    queue_request(REQ_DROP_FRONT, '0);
    queue_request(REQ_DROP_BACK, '0);
    queue_request(REQ_PUSH_FRONT, 32'sh7fff_ffff);
    queue_request(REQ_PUSH_BACK, 32'sh8000_0000);
    queue_request(REQ_PUSH_FRONT, -1);
    queue_request(REQ_PUSH_BACK, '0);
    queue_request(REQ_PUSH_FRONT, 32'sd1);
    queue_request(REQ_LIST, '0);
    queue_request(REQ_DROP_FRONT, -1);
    queue_request(REQ_DROP_BACK, 32'sh7fff_ffff);
    queue_request(REQ_LIST, '0);
    queue_request(REQ_RSVD_5, -1);
    queue_request(REQ_RSVD_6, 32'sh5a5a_a5a5);
    queue_request(REQ_RSVD_7, '0);
    queue_request(REQ_PUSH_BACK, 32'sh5555_5555);
    queue_request(REQ_LIST, '0);
    for (k = 0; k < 4; k++) queue_request(REQ_DROP_BACK, '0);
    queue_request(REQ_DROP_FRONT, '0);
    queue_request(REQ_LIST, '0);
    while (accepted_count != queued_count) @(negedge clk_i);

    // receiver holds off while requests that fill the deque and push past capacity back up
    hold_requests++;
    repeat (2) @(negedge clk_i);
    for (k = 0; k < DEPTH; k++)
      queue_request(k[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom);
    queue_request(REQ_PUSH_FRONT, 32'sd11);
    queue_request(REQ_PUSH_BACK, 32'sd22);
    queue_request(REQ_LIST, '0);
    // sender pauses until the backlog has fully drained
    while (accepted_count != queued_count || expected_replies.size() != 0) @(negedge clk_i);

    run_random_phase(0, 0, 27);
    run_random_phase(59, 0, 27);
    run_random_phase(0, 59, 27);
    run_random_phase(18, 18, 27);

    while (expected_replies.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("circular_deque_ring verification clean");
    end else begin
      $display("circular_deque_ring verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("circular_deque_ring verification failed");
    $finish;
  end

endmodule
